[rtl/npt_pkg.sv]
// Package for the node parent table: widths, action and status codes.
// Used by node_parent_table_core and by its checker.
package npt_pkg;

    localparam int ADDR_W         = 16;
    localparam int TOTAL_W        = 6;
    localparam int TABLE_DEPTH_DEF = 32;

    localparam logic ACT_SET = 1'b0;
    localparam logic ACT_GET = 1'b1;

    localparam logic STAT_DONE = 1'b0;
    localparam logic STAT_FULL = 1'b1;

endpackage

[rtl/node_parent_table_core.sv]
// Node parent table: maps a node address to its parent, searching one entry per cycle.
// An item holds the block, with in_ready low, from accept until its result enters the output register.
// A finished result waits in the output register; the next item is accepted meanwhile and its
// result is held back until that register has been emptied.
// Reset (rst_n, asynchronous, active low) clears the count and control state, not the memories.
module node_parent_table_core
    import npt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [ADDR_W-1:0] node_addr,
    input  logic [ADDR_W-1:0] parent_addr,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              status,
    output logic              found,
    output logic [ADDR_W-1:0] parent_out,
    output logic [TOTAL_W-1:0] entry_total
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DONE   = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic               act_reg, act_next;
    logic [ADDR_W-1:0]  node_reg, node_next;
    logic [ADDR_W-1:0]  par_reg, par_next;
    logic               out_vld_reg, out_vld_next;
    logic               status_reg, status_next;
    logic               found_reg, found_next;
    logic [ADDR_W-1:0]  pout_reg, pout_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic [ADDR_W-1:0]  key_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]  parent_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]  key_rd_reg;
    logic [ADDR_W-1:0]  parent_rd_reg;

    logic               rd_en;
    logic               key_wr_en;
    logic               par_wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               cmp_hit;
    logic [CNT_W+TOTAL_W-1:0] count_wide;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_vld_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign parent_out  = pout_reg;
    assign entry_total = total_reg;

    assign cmp_hit    = chk_vld_reg && (key_rd_reg == node_reg);
    assign count_wide = {{TOTAL_W{1'b0}}, count_next};

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        chk_vld_next = 1'b0;
        chk_idx_next = chk_idx_reg;
        hit_next     = hit_reg;
        slot_next    = slot_reg;
        act_next     = act_reg;
        node_next    = node_reg;
        par_next     = par_reg;
        out_vld_next = out_vld_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        pout_next    = pout_reg;
        total_next   = total_reg;
        rd_en        = 1'b0;
        key_wr_en    = 1'b0;
        par_wr_en    = 1'b0;
        wr_addr      = count_reg[IDX_W-1:0];

        if (out_vld_reg && out_ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    node_next  = node_addr;
                    par_next   = parent_addr;
                    scan_next  = '0;
                    hit_next   = 1'b0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (cmp_hit)
                begin
                    hit_next   = 1'b1;
                    slot_next  = chk_idx_reg;
                    state_next = ST_DONE;
                end
                else if (scan_reg != count_reg)
                begin
                    rd_en        = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = scan_reg[IDX_W-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    status_next = STAT_DONE;
                    found_next  = hit_reg;
                    pout_next   = '0;
                    if (act_reg == ACT_SET)
                    begin
                        if (hit_reg)
                        begin
                            par_wr_en = 1'b1;
                            wr_addr   = slot_reg;
                        end
                        else if (count_reg == DEPTH_CNT)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            key_wr_en  = 1'b1;
                            par_wr_en  = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (hit_reg)
                    begin
                        pout_next = parent_rd_reg;
                    end
                    total_next   = count_wide[TOTAL_W-1:0];
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            scan_reg    <= '0;
            chk_vld_reg <= 1'b0;
            chk_idx_reg <= '0;
            hit_reg     <= 1'b0;
            slot_reg    <= '0;
            act_reg     <= ACT_SET;
            node_reg    <= '0;
            par_reg     <= '0;
            out_vld_reg <= 1'b0;
            status_reg  <= STAT_DONE;
            found_reg   <= 1'b0;
            pout_reg    <= '0;
            total_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            chk_vld_reg <= chk_vld_next;
            chk_idx_reg <= chk_idx_next;
            hit_reg     <= hit_next;
            slot_reg    <= slot_next;
            act_reg     <= act_next;
            node_reg    <= node_next;
            par_reg     <= par_next;
            out_vld_reg <= out_vld_next;
            status_reg  <= status_next;
            found_reg   <= found_next;
            pout_reg    <= pout_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            key_rd_reg    <= key_mem[scan_reg[IDX_W-1:0]];
            parent_rd_reg <= parent_mem[scan_reg[IDX_W-1:0]];
        end
        if (key_wr_en)
        begin
            key_mem[wr_addr] <= node_reg;
        end
        if (par_wr_en)
        begin
            parent_mem[wr_addr] <= par_reg;
        end
    end

endmodule

[rtl/npt_checker.sv]
// Port-level checker for node_parent_table_core, bound into that module.
// Depends on npt_pkg for widths and codes.
module npt_checker
    import npt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               action,
    input logic [ADDR_W-1:0]  node_addr,
    input logic [ADDR_W-1:0]  parent_addr,
    input logic               out_valid,
    input logic               out_ready,
    input logic               status,
    input logic               found,
    input logic [ADDR_W-1:0]  parent_out,
    input logic [TOTAL_W-1:0] entry_total
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found)
            && $stable(parent_out) && $stable(entry_total))
        else $error("Stalled result item changed.");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_FULL) |-> !found && (parent_out == '0))
        else $error("Refused set reports a found node or a parent.");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (TABLE_DEPTH > 63) || (int'(entry_total) <= TABLE_DEPTH))
        else $error("Entry total exceeds the table depth.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input ready stayed high after an item was accepted.");

endmodule

bind node_parent_table_core npt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_npt_checker (.*);
